/* rtl/afk_pkg.sv */
// ----------------------------------------------------------------------------
// afk_pkg
// Shared types, constants and helpers for the five-joint arm kinematics block.
// ----------------------------------------------------------------------------
`default_nettype none

package afk_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 30;
    localparam int POLY_W     = FRAC_BITS + 1;
    localparam int TRIG_W     = 18;
    localparam int SUM_W      = 32;
    localparam int LEN_W      = 23;
    localparam int POS_W      = 24;
    localparam int IDX_W      = 4;
    localparam int NUM_CELLS  = 4;
    localparam int LANE_LAT   = NUM_CELLS + 4;
    localparam int COMB_LAT   = 5;
    localparam int PIPE_LAT   = LANE_LAT + COMB_LAT;

    localparam logic [POLY_W-1:0] ONE_Q30 = POLY_W'(1) << FRAC_BITS;
    localparam logic [POLY_W-1:0] K9      = POLY_W'(172272);
    localparam logic [POLY_W-1:0] HORNER_K [NUM_CELLS] = '{
        POLY_W'(5026995), POLY_W'(85569306), POLY_W'(693598668), POLY_W'(1686629713)
    };

    localparam logic [TRIG_W-1:0] TRIG_ONE = TRIG_W'(65536);
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(8388608);

    localparam logic [LEN_W-1:0] UPPER_ARM_RESET = LEN_W'(1572864);
    localparam logic [LEN_W-1:0] FOREARM_RESET   = LEN_W'(917504);
    localparam logic [LEN_W-1:0] TOOL_RESET      = LEN_W'(655360);
    localparam logic [LEN_W-1:0] BASE_RESET      = LEN_W'(524288);

    typedef enum logic [IDX_W-1:0] {
        REG_UPPER_ARM = IDX_W'(0),
        REG_FOREARM   = IDX_W'(1),
        REG_TOOL      = IDX_W'(2),
        REG_BASE      = IDX_W'(3)
    } afk_reg_idx_t;

    typedef logic signed [TRIG_W-1:0] trig_t;

    // data handed from one polynomial cell to the next
    typedef struct packed {
        logic [POLY_W-1:0] p;
        logic [POLY_W-1:0] t;
        logic [POLY_W-1:0] t2;
        logic              neg;
    } afk_cell_t;

    // Q16 product, rounded half up (floor of (a*b + 2^15) / 2^16)
    function automatic logic signed [SUM_W-1:0] qmul(input logic signed [SUM_W-1:0] a,
                                                    input logic signed [SUM_W-1:0] b);
        logic signed [2*SUM_W-1:0] prod;
        prod = (2*SUM_W)'(a) * (2*SUM_W)'(b) + (2*SUM_W)'(32768);
        return prod[SUM_W+15:16];
    endfunction

    function automatic logic signed [SUM_W-1:0] trig_ext(input trig_t v);
        return SUM_W'(v);
    endfunction

    function automatic logic signed [SUM_W-1:0] len_ext(input logic [LEN_W-1:0] v);
        return signed'({{(SUM_W-LEN_W){1'b0}}, v});
    endfunction

endpackage

`default_nettype wire

/* rtl/arm_forward_kinematics_5dof_top.sv */
// ----------------------------------------------------------------------------
// arm_forward_kinematics_5dof_top
// Tool position of a five-joint arm from its joint angles.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with the five joint angles (16-bit turn fractions); busy is
//   always low, so a transfer takes place on every clock edge with start
//   high, one per cycle back to back.
//   For each transfer, done is later high for one cycle with pos_x, pos_y and
//   pos_z (signed Q8.16, saturated). The path runs through the sine lanes
//   (fold, squaring, four Horner cells, scale, round) and the
//   five-stage product and sum pipeline. Throughput: one set per cycle.
//   The receiver cannot stall; results are shown once.
//   Link lengths and base height are written through wr_en / wr_index /
//   wr_data while no set is in flight; indexes above three are ignored.
//   Reset clears the in-flight marks and loads the default lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module arm_forward_kinematics_5dof_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [afk_pkg::ANGLE_BITS-1:0] joint_one,
    input  wire logic [afk_pkg::ANGLE_BITS-1:0] joint_two,
    input  wire logic [afk_pkg::ANGLE_BITS-1:0] joint_three,
    input  wire logic [afk_pkg::ANGLE_BITS-1:0] joint_four,
    input  wire logic [afk_pkg::ANGLE_BITS-1:0] joint_five,
    input  wire logic                          wr_en,
    input  wire logic [afk_pkg::IDX_W-1:0]      wr_index,
    input  wire logic [afk_pkg::LEN_W-1:0]      wr_data,
    output logic                               done,
    output logic signed [afk_pkg::POS_W-1:0]    pos_x,
    output logic signed [afk_pkg::POS_W-1:0]    pos_y,
    output logic signed [afk_pkg::POS_W-1:0]    pos_z
);
    import afk_pkg::*;

    localparam int NUM_LANES = 10;

    logic [LEN_W-1:0] upper_arm_reg, forearm_reg, tool_reg, base_reg;
    logic [PIPE_LAT-1:0] valid_reg;
    logic [PIPE_LAT-1:0] valid_next;
    logic [ANGLE_BITS-1:0] lane_angle [NUM_LANES];
    trig_t                 lane_sine  [NUM_LANES];
    logic [ANGLE_BITS-1:0] sum23;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_arm_reg <= UPPER_ARM_RESET;
            forearm_reg   <= FOREARM_RESET;
            tool_reg      <= TOOL_RESET;
            base_reg      <= BASE_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_UPPER_ARM: upper_arm_reg <= wr_data;
                REG_FOREARM:   forearm_reg   <= wr_data;
                REG_TOOL:      tool_reg      <= wr_data;
                REG_BASE:      base_reg      <= wr_data;
                default:       ;
            endcase
        end
    end

    assign valid_next = {valid_reg[PIPE_LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign done  = valid_reg[PIPE_LAT-1];
    assign sum23 = joint_two + joint_three;

    // even lanes sine, odd lanes cosine (a quarter turn ahead)
    assign lane_angle[0] = joint_one;
    assign lane_angle[1] = joint_one + QUARTER_TURN;
    assign lane_angle[2] = joint_two;
    assign lane_angle[3] = joint_two + QUARTER_TURN;
    assign lane_angle[4] = joint_four;
    assign lane_angle[5] = joint_four + QUARTER_TURN;
    assign lane_angle[6] = joint_five;
    assign lane_angle[7] = joint_five + QUARTER_TURN;
    assign lane_angle[8] = sum23;
    assign lane_angle[9] = sum23 + QUARTER_TURN;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        afk_sine_lane u_lane (
            .clk   (clk),
            .angle (lane_angle[i]),
            .sine  (lane_sine[i])
        );
    end

    afk_combine u_combine (
        .clk              (clk),
        .s1               (lane_sine[0]),
        .c1               (lane_sine[1]),
        .s2               (lane_sine[2]),
        .c2               (lane_sine[3]),
        .s4               (lane_sine[4]),
        .c4               (lane_sine[5]),
        .s5               (lane_sine[6]),
        .c5               (lane_sine[7]),
        .s23              (lane_sine[8]),
        .c23              (lane_sine[9]),
        .upper_arm_length (upper_arm_reg),
        .forearm_length   (forearm_reg),
        .tool_length      (tool_reg),
        .base_height      (base_reg),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .pos_z            (pos_z)
    );

endmodule

`default_nettype wire

/* rtl/afk_horner_cell.sv */
// ----------------------------------------------------------------------------
// afk_horner_cell
// One Horner step of the quarter-sine polynomial: p <= k - p*t^2.
// ----------------------------------------------------------------------------
`default_nettype none

module afk_horner_cell (
    input  wire logic                      clk,
    input  wire logic [afk_pkg::POLY_W-1:0] coef,
    input  wire afk_pkg::afk_cell_t        cell_in,
    output afk_pkg::afk_cell_t             cell_out
);
    import afk_pkg::*;

    logic [2*POLY_W-1:0] prod;
    afk_cell_t           cell_reg;
    afk_cell_t           cell_next;

    always_comb
    begin
        prod = (2*POLY_W)'(cell_in.p) * (2*POLY_W)'(cell_in.t2);
        cell_next    = cell_in;
        cell_next.p  = coef - prod[FRAC_BITS+POLY_W-1:FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

/* rtl/afk_sine_lane.sv */
// ----------------------------------------------------------------------------
// afk_sine_lane
// Pipelined sine of a turn fraction: quadrant fold, a row of Horner cells,
// final scale, rounding to Q1.16 and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module afk_sine_lane (
    input  wire logic                          clk,
    input  wire logic [afk_pkg::ANGLE_BITS-1:0] angle,
    output afk_pkg::trig_t                     sine
);
    import afk_pkg::*;

    logic [POLY_W-1:0]   r_base;
    logic [POLY_W-1:0]   r_next;
    logic [POLY_W-1:0]   r_reg;
    logic                neg_reg;
    logic [2*POLY_W-1:0] sq_prod;
    afk_cell_t           head_reg;
    afk_cell_t           chain [NUM_CELLS+1];
    logic [2*POLY_W-1:0] fin_prod;
    logic [POLY_W-1:0]   q_reg;
    logic                q_neg_reg;
    logic [POLY_W:0]     q_round;
    logic [TRIG_W-1:0]   mag;
    trig_t               sine_next;
    trig_t               sine_reg;

    // position inside the quadrant, mirrored on odd quadrants
    always_comb
    begin
        r_base = POLY_W'({angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});
        r_next = angle[ANGLE_BITS-2] ? (ONE_Q30 - r_base) : r_base;
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        neg_reg <= angle[ANGLE_BITS-1];
    end

    assign sq_prod = (2*POLY_W)'(r_reg) * (2*POLY_W)'(r_reg);

    always_ff @(posedge clk)
    begin
        head_reg.p   <= K9;
        head_reg.t   <= r_reg;
        head_reg.t2  <= sq_prod[FRAC_BITS+POLY_W-1:FRAC_BITS];
        head_reg.neg <= neg_reg;
    end

    assign chain[0] = head_reg;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        afk_horner_cell u_cell (
            .clk      (clk),
            .coef     (HORNER_K[i]),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    assign fin_prod = (2*POLY_W)'(chain[NUM_CELLS].p) * (2*POLY_W)'(chain[NUM_CELLS].t);

    always_ff @(posedge clk)
    begin
        q_reg     <= fin_prod[FRAC_BITS+POLY_W-1:FRAC_BITS];
        q_neg_reg <= chain[NUM_CELLS].neg;
    end

    always_comb
    begin
        q_round = (POLY_W+1)'(q_reg) + (POLY_W+1)'(8192);
        mag     = q_round[POLY_W:14];
        if (mag > TRIG_ONE)
        begin
            mag = TRIG_ONE;
        end
        sine_next = q_neg_reg ? -signed'(mag) : signed'(mag);
    end

    always_ff @(posedge clk)
    begin
        sine_reg <= sine_next;
    end

    assign sine = sine_reg;

endmodule

`default_nettype wire

/* rtl/afk_combine.sv */
// ----------------------------------------------------------------------------
// afk_combine
// Pipelined position equations: products of sines, cosines and link
// lengths, sums and saturation to signed Q8.16.
// ----------------------------------------------------------------------------
`default_nettype none

module afk_combine (
    input  wire logic                     clk,
    input  wire afk_pkg::trig_t           s1,
    input  wire afk_pkg::trig_t           c1,
    input  wire afk_pkg::trig_t           s2,
    input  wire afk_pkg::trig_t           c2,
    input  wire afk_pkg::trig_t           s4,
    input  wire afk_pkg::trig_t           c4,
    input  wire afk_pkg::trig_t           s5,
    input  wire afk_pkg::trig_t           c5,
    input  wire afk_pkg::trig_t           s23,
    input  wire afk_pkg::trig_t           c23,
    input  wire logic [afk_pkg::LEN_W-1:0] upper_arm_length,
    input  wire logic [afk_pkg::LEN_W-1:0] forearm_length,
    input  wire logic [afk_pkg::LEN_W-1:0] tool_length,
    input  wire logic [afk_pkg::LEN_W-1:0] base_height,
    output logic signed [afk_pkg::POS_W-1:0] pos_x,
    output logic signed [afk_pkg::POS_W-1:0] pos_y,
    output logic signed [afk_pkg::POS_W-1:0] pos_z
);
    import afk_pkg::*;

    typedef logic signed [SUM_W-1:0] sum_t;

    sum_t l2, l3, tl, hb;

    // first products
    sum_t c5s23_reg, s5c4_reg, s5s4_reg, s23c4_reg, c23c5_reg;
    sum_t l2c2_reg, l3s23_reg, l2s2_reg, l3c23_reg;
    sum_t a_s1_reg, a_c1_reg, a_c23_reg, a_s5_reg;
    // second
    sum_t b_c5s23_reg, w2_reg, side_reg, zt1_reg, zt2_reg, arm_reg, zbase_reg;
    sum_t b_s1_reg, b_c1_reg;
    // third
    sum_t reach_t_reg, zt1b_reg, c_side_reg, c_arm_reg, c_z_reg, c_s1_reg, c_c1_reg;
    // fourth
    sum_t px1_reg, px2_reg, py1_reg, py2_reg, d_z_reg;
    sum_t reach;
    sum_t px, py;
    logic signed [POS_W-1:0] x_reg, y_reg, z_reg;

    assign l2 = len_ext(upper_arm_length);
    assign l3 = len_ext(forearm_length);
    assign tl = len_ext(tool_length);
    assign hb = len_ext(base_height);

    always_ff @(posedge clk)
    begin
        c5s23_reg <= qmul(trig_ext(c5), trig_ext(s23));
        s5c4_reg  <= qmul(trig_ext(s5), trig_ext(c4));
        s5s4_reg  <= qmul(trig_ext(s5), trig_ext(s4));
        s23c4_reg <= qmul(trig_ext(s23), trig_ext(c4));
        c23c5_reg <= qmul(trig_ext(c23), trig_ext(c5));
        l2c2_reg  <= qmul(l2, trig_ext(c2));
        l3s23_reg <= qmul(l3, trig_ext(s23));
        l2s2_reg  <= qmul(l2, trig_ext(s2));
        l3c23_reg <= qmul(l3, trig_ext(c23));
        a_s1_reg  <= trig_ext(s1);
        a_c1_reg  <= trig_ext(c1);
        a_c23_reg <= trig_ext(c23);
        a_s5_reg  <= trig_ext(s5);
    end

    always_ff @(posedge clk)
    begin
        b_c5s23_reg <= c5s23_reg;
        w2_reg      <= qmul(s5c4_reg, a_c23_reg);
        side_reg    <= qmul(tl, s5s4_reg);
        zt1_reg     <= qmul(s23c4_reg, a_s5_reg);
        zt2_reg     <= qmul(tl, c23c5_reg);
        arm_reg     <= l2c2_reg + l3s23_reg;
        zbase_reg   <= l2s2_reg - l3c23_reg + hb;
        b_s1_reg    <= a_s1_reg;
        b_c1_reg    <= a_c1_reg;
    end

    always_ff @(posedge clk)
    begin
        reach_t_reg <= qmul(tl, b_c5s23_reg + w2_reg);
        zt1b_reg    <= qmul(tl, zt1_reg);
        c_side_reg  <= side_reg;
        c_arm_reg   <= arm_reg;
        c_z_reg     <= zbase_reg - zt2_reg;
        c_s1_reg    <= b_s1_reg;
        c_c1_reg    <= b_c1_reg;
    end

    assign reach = c_arm_reg + reach_t_reg;

    always_ff @(posedge clk)
    begin
        px1_reg <= qmul(c_c1_reg, reach);
        px2_reg <= qmul(c_s1_reg, c_side_reg);
        py1_reg <= qmul(c_s1_reg, reach);
        py2_reg <= qmul(c_c1_reg, c_side_reg);
        d_z_reg <= c_z_reg + zt1b_reg;
    end

    function automatic logic signed [POS_W-1:0] sat(input sum_t v);
        sum_t w;
        w = v;
        if (w > POS_MAX)
        begin
            w = POS_MAX;
        end
        if (w < POS_MIN)
        begin
            w = POS_MIN;
        end
        return w[POS_W-1:0];
    endfunction

    assign px = px1_reg + px2_reg;
    assign py = py1_reg - py2_reg;

    always_ff @(posedge clk)
    begin
        x_reg <= sat(px);
        y_reg <= sat(py);
        z_reg <= sat(d_z_reg);
    end

    assign pos_x = x_reg;
    assign pos_y = y_reg;
    assign pos_z = z_reg;

endmodule

`default_nettype wire

/* rtl/afk_checker.sv */
// ----------------------------------------------------------------------------
// afk_checker
// Port-level checks on the kinematics block: busy stays low, latency and strobe count.
// ----------------------------------------------------------------------------
`default_nettype none

module afk_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);
    import afk_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("transfer without result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##PIPE_LAT !done)
        else $error("result without transfer");

endmodule

bind arm_forward_kinematics_5dof_top afk_checker u_afk_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire

/* verif/arm_forward_kinematics_5dof_checker.sv */
// ----------------------------------------------------------------------------
// arm_forward_kinematics_5dof_checker
// Watches joint-angle transfers and position results of the arm kinematics
// block, computes the expected tool position in fixed point and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arm_forward_kinematics_5dof_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [afk_pkg::ANGLE_BITS-1:0]    joint_one,
    input  logic [afk_pkg::ANGLE_BITS-1:0]    joint_two,
    input  logic [afk_pkg::ANGLE_BITS-1:0]    joint_three,
    input  logic [afk_pkg::ANGLE_BITS-1:0]    joint_four,
    input  logic [afk_pkg::ANGLE_BITS-1:0]    joint_five,
    input  logic                              wr_en,
    input  logic [afk_pkg::IDX_W-1:0]         wr_index,
    input  logic [afk_pkg::LEN_W-1:0]         wr_data,
    input  logic                              done,
    input  logic signed [afk_pkg::POS_W-1:0]  pos_x,
    input  logic signed [afk_pkg::POS_W-1:0]  pos_y,
    input  logic signed [afk_pkg::POS_W-1:0]  pos_z,
    output int                                fail_count,
    output int                                pending
);
    import afk_pkg::*;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } position_t;

    localparam longint C1 = 1686629713;
    localparam longint C3 = 693598668;
    localparam longint C5 = 85569306;
    localparam longint C7 = 5026995;
    localparam longint C9 = 172272;

    logic [LEN_W-1:0] upper_len, fore_len, tool_len, base_h;
    position_t        position_q[$];
    int               mismatches;

    function automatic longint poly_sine(longint t);
        longint t2, p;
        t2 = (t * t) >>> 30;
        p = C9;
        p = C7 - ((p * t2) >>> 30);
        p = C5 - ((p * t2) >>> 30);
        p = C3 - ((p * t2) >>> 30);
        p = C1 - ((p * t2) >>> 30);
        return (p * t) >>> 30;
    endfunction

    function automatic longint sine_q16(logic [31:0] u);
        longint r, s;
        r = longint'(u[29:0]);
        if (u[30])
            r = (longint'(1) << 30) - r;
        s = (poly_sine(r) + 8192) >>> 14;
        if (s > 65536)
            s = 65536;
        return u[31] ? -s : s;
    endfunction

    // half-up rounding: floor of (a*b + 2^15) / 2^16
    function automatic longint rmul(longint a, longint b);
        return (a * b + 32768) >>> 16;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp(longint v);
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return v[POS_W-1:0];
    endfunction

    function automatic position_t tool_position(logic [15:0] a1, logic [15:0] a2,
                                                logic [15:0] a3, logic [15:0] a4,
                                                logic [15:0] a5);
        logic [31:0] u1, u2, u4, u5, u23, qt;
        longint s1, c1, s2, c2, s4, c4, s5, c5, s23, c23;
        longint l2, l3, tl, wrist, reach, side;
        position_t r;
        qt = 32'h4000_0000;
        u1 = {a1, 16'h0};
        u2 = {a2, 16'h0};
        u4 = {a4, 16'h0};
        u5 = {a5, 16'h0};
        u23 = u2 + {a3, 16'h0};
        s1 = sine_q16(u1);   c1 = sine_q16(u1 + qt);
        s2 = sine_q16(u2);   c2 = sine_q16(u2 + qt);
        s4 = sine_q16(u4);   c4 = sine_q16(u4 + qt);
        s5 = sine_q16(u5);   c5 = sine_q16(u5 + qt);
        s23 = sine_q16(u23); c23 = sine_q16(u23 + qt);
        l2 = longint'(upper_len);
        l3 = longint'(fore_len);
        tl = longint'(tool_len);
        wrist = rmul(c5, s23) + rmul(rmul(s5, c4), c23);
        reach = rmul(l2, c2) + rmul(l3, s23) + rmul(tl, wrist);
        side = rmul(tl, rmul(s5, s4));
        r.x = clamp(rmul(c1, reach) + rmul(s1, side));
        r.y = clamp(rmul(s1, reach) - rmul(c1, side));
        r.z = clamp(rmul(l2, s2) - rmul(l3, c23) + rmul(tl, rmul(rmul(s23, c4), s5))
                    - rmul(tl, rmul(c23, c5)) + longint'(base_h));
        return r;
    endfunction

    assign fail_count = mismatches;
    assign pending = position_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        position_t want;
        if (!rst_n)
        begin
            upper_len <= UPPER_ARM_RESET;
            fore_len  <= FOREARM_RESET;
            tool_len  <= TOOL_RESET;
            base_h    <= BASE_RESET;
            position_q.delete();
            mismatches <= 0;
        end
        else
        begin
            if (done)
            begin
                if (position_q.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("%0t: unexpected result x=%0d y=%0d z=%0d",
                                 $realtime, pos_x, pos_y, pos_z);
                end
                else
                begin
                    want = position_q.pop_front();
                    if (want.x !== pos_x || want.y !== pos_y || want.z !== pos_z)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("%0t: mismatch exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                                     $realtime, want.x, want.y, want.z, pos_x, pos_y, pos_z);
                    end
                end
            end
            if (start && !busy)
                position_q.push_back(tool_position(joint_one, joint_two, joint_three,
                                                   joint_four, joint_five));
            if (wr_en)
            begin
                case (wr_index)
                    REG_UPPER_ARM: upper_len <= wr_data;
                    REG_FOREARM:   fore_len  <= wr_data;
                    REG_TOOL:      tool_len  <= wr_data;
                    REG_BASE:      base_h    <= wr_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

/* verif/arm_forward_kinematics_5dof_top_tb.sv */
// ----------------------------------------------------------------------------
// arm_forward_kinematics_5dof_top_tb
// Drives directed and random joint-angle sets through several link settings
// in bursts with gaps; the checker predicts and compares every position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arm_forward_kinematics_5dof_top_tb;
    import afk_pkg::*;

    localparam int WATCHDOG = 2000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [ANGLE_BITS-1:0]    joint_one = '0, joint_two = '0, joint_three = '0;
    logic [ANGLE_BITS-1:0]    joint_four = '0, joint_five = '0;
    logic                     wr_en = 1'b0;
    logic [IDX_W-1:0]         wr_index = '0;
    logic [LEN_W-1:0]         wr_data = '0;
    logic                     done;
    logic signed [POS_W-1:0]  pos_x, pos_y, pos_z;
    int                       fail_count, pending;
    int                       idle_cycles = 0;

    always #5 clk = ~clk;

    arm_forward_kinematics_5dof_top uut (.*);

    arm_forward_kinematics_5dof_checker chk (.*);

    // watchdog: cycles with no transfer in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("arm_forward_kinematics_5dof_top_tb: FAIL");
            $finish;
        end
    end

    task automatic send_angles(input logic [15:0] a1, a2, a3, a4, a5);
        start       <= 1'b1;
        joint_one   <= a1;
        joint_two   <= a2;
        joint_three <= a3;
        joint_four  <= a4;
        joint_five  <= a5;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic write_reg(input afk_reg_idx_t idx, input logic [LEN_W-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] edge_angle();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h4000;
            3: return 16'h8000;
            4: return 16'hC000;
            default: return 16'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
        endcase
    endfunction

    task automatic random_phase(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < count)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_angles(edge_angle(), edge_angle(), edge_angle(),
                                edge_angle(), edge_angle());
                else
                    send_angles(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom));
                burst--;
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 16));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero pose, field extremes, quadrant boundaries and mixed angles
        send_angles(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_angles(16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'h4000);
        send_angles(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_angles(16'hC000, 16'hC000, 16'hC000, 16'hC000, 16'hC000);
        send_angles(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        send_angles(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_angles(16'h3FFF, 16'h4001, 16'hBFFF, 16'h7FFF, 16'h0001);
        send_angles(16'h2000, 16'hE000, 16'h6000, 16'hA000, 16'h1234);
        drain();

        // saturation: longest links and highest base
        write_reg(REG_UPPER_ARM, 23'h7FFFFF);
        write_reg(REG_FOREARM,   23'h7FFFFF);
        write_reg(REG_TOOL,      23'h7FFFFF);
        write_reg(REG_BASE,      23'h7FFFFF);
        send_angles(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_angles(16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000);
        send_angles(16'h8000, 16'hC000, 16'h8000, 16'h0000, 16'hC000);
        send_angles(16'h4000, 16'h0000, 16'h4000, 16'h8000, 16'h4000);
        send_angles(16'hC000, 16'h8000, 16'h4000, 16'h4000, 16'h8000);
        random_phase(150);
        drain();

        // all lengths zero, then an ignored index
        write_reg(REG_UPPER_ARM, '0);
        write_reg(REG_FOREARM,   '0);
        write_reg(REG_TOOL,      '0);
        write_reg(REG_BASE,      '0);
        wr_en    <= 1'b1;
        wr_index <= IDX_W'(4'hF);
        wr_data  <= 23'h7FFFFF;
        @(posedge clk);
        wr_en    <= 1'b0;
        wr_index <= IDX_W'(4'h4);
        send_angles(16'h1234, 16'h4321, 16'h0F0F, 16'hF0F0, 16'h7777);
        random_phase(100);
        drain();

        // reset defaults, then random lengths
        write_reg(REG_UPPER_ARM, UPPER_ARM_RESET);
        write_reg(REG_FOREARM,   FOREARM_RESET);
        write_reg(REG_TOOL,      TOOL_RESET);
        write_reg(REG_BASE,      BASE_RESET);
        random_phase(300);
        drain();

        repeat (3)
        begin
            write_reg(REG_UPPER_ARM, LEN_W'($urandom));
            write_reg(REG_FOREARM,   LEN_W'($urandom));
            write_reg(REG_TOOL,      LEN_W'($urandom));
            write_reg(REG_BASE,      LEN_W'($urandom));
            random_phase(160);
            drain();
        end

        if (fail_count == 0)
            $display("arm_forward_kinematics_5dof_top_tb: PASS");
        else
            $display("arm_forward_kinematics_5dof_top_tb: FAIL");
        $finish;
    end

endmodule
